>>> src/cmxd_pkg.sv
// Shared types and constants for the complex mixer and decimator.
`default_nettype none

package cmxd_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MIX_ENABLE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_REAL    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_IMAG    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIM_FACTOR = 8'd3;

  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741823;

  typedef struct packed {
    logic signed [15:0] in_real;
    logic signed [15:0] in_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_real;
    logic signed [15:0] out_imag;
  } out_item_t;

  typedef struct packed {
    in_item_t sample;
    logic     keep;
  } q_item_t;

  typedef struct packed {
    logic               mix_enable;
    logic signed [30:0] step_real;
    logic signed [30:0] step_imag;
    logic [10:0]        decim_factor;
  } cfg_t;

endpackage

`default_nettype wire

>>> src/cmxd_front.sv
// Front end: accepts samples and marks each one as kept or dropped.
`default_nettype none

module cmxd_front #(
  parameter int MAX_DECIM = 1024
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  cmxd_pkg::in_item_t  in_data,
  input  wire  [10:0]         decim_factor,
  input  wire                 q_full,
  output logic                q_push,
  output cmxd_pkg::q_item_t   q_item
);
  import cmxd_pkg::*;

  localparam int KW = $clog2(MAX_DECIM);
  localparam int FW = 18;

  logic [KW-1:0] keep_count_r;
  logic [FW-1:0] count_inc;
  logic [FW-1:0] factor;
  logic [FW-1:0] factor_lim;

  assign in_ready   = !q_full;
  assign q_push     = in_valid && in_ready;
  assign count_inc  = FW'(keep_count_r) + FW'(1);
  assign factor     = FW'(decim_factor);
  assign factor_lim = (factor > FW'(MAX_DECIM)) ? FW'(MAX_DECIM) : factor;

  always_comb begin
    q_item.sample = in_data;
    q_item.keep   = (keep_count_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= '0;
    end else if (q_push) begin
      if (count_inc >= factor_lim) begin
        keep_count_r <= '0;
      end else begin
        keep_count_r <= count_inc[KW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

>>> src/cmxd_queue.sv
// Two-entry queue between the front end and the arithmetic back end.
`default_nettype none

module cmxd_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  cmxd_pkg::q_item_t  push_item,
  output logic               full,
  input  wire                pop,
  output logic               pop_valid,
  output cmxd_pkg::q_item_t  pop_item
);
  import cmxd_pkg::*;

  q_item_t    entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_item  = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

>>> src/cmxd_back.sv
// Back end: mixes samples, or passes them through with mixing off, and steps the phasor on one shared multiplier.
`default_nettype none

module cmxd_back #(
  parameter int RENORM_PERIOD = 512
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  cmxd_pkg::cfg_t      cfg,
  input  wire                 q_valid,
  input  cmxd_pkg::q_item_t   q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output cmxd_pkg::out_item_t out_data
);
  import cmxd_pkg::*;

  localparam int RW = $clog2(RENORM_PERIOD);

  localparam logic [3:0] S_A_PR  = 4'd0;
  localparam logic [3:0] S_B_PI  = 4'd1;
  localparam logic [3:0] S_A_PI  = 4'd2;
  localparam logic [3:0] S_B_PR  = 4'd3;
  localparam logic [3:0] S_PR_SR = 4'd4;
  localparam logic [3:0] S_PI_SI = 4'd5;
  localparam logic [3:0] S_PR_SI = 4'd6;
  localparam logic [3:0] S_PI_SR = 4'd7;
  localparam logic [3:0] S_PR_SQ = 4'd8;
  localparam logic [3:0] S_PI_SQ = 4'd9;
  localparam logic [3:0] S_GAIN  = 4'd10;
  localparam logic [3:0] S_PR_G  = 4'd11;
  localparam logic [3:0] S_PI_G  = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  typedef enum logic [1:0] {IDLE, RUN, HOLD} state_t;

  state_t             state_r;
  logic [3:0]         step_r;
  logic [3:0]         tag_r;
  logic               pvalid_r;
  logic               renorm_r;
  logic [RW-1:0]      rcount_r;
  logic signed [15:0] a_r;
  logic signed [15:0] b_r;
  logic               keep_r;
  logic signed [15:0] yr_r;
  logic signed [15:0] yi_r;
  logic signed [31:0] pr_r;
  logic signed [31:0] pi_r;
  logic signed [32:0] g_r;
  logic signed [65:0] prod_r;
  logic signed [65:0] acc_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic signed [32:0] op_x;
  logic signed [32:0] op_y;
  logic signed [65:0] mul;
  logic               issue;
  logic [3:0]         end_step;
  logic signed [66:0] sum_add;
  logic signed [66:0] sum_sub;
  logic signed [66:0] sq_t;
  logic [32:0]        mag;
  logic signed [33:0] gain_w;

  function automatic logic signed [66:0] rnd30(input logic signed [66:0] v);
    rnd30 = (v + 67'sd536870912) >>> 30;
  endfunction

  function automatic logic signed [66:0] rnd31(input logic signed [66:0] v);
    rnd31 = (v + 67'sd1073741824) >>> 31;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [66:0] v);
    if (v > 67'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -67'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    if (v > 67'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -67'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  assign q_pop     = (state_r == IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign end_step  = renorm_r ? S_DONE : S_PR_SQ;
  assign mul       = op_x * op_y;
  assign sum_add   = {acc_r[65], acc_r} + {prod_r[65], prod_r};
  assign sum_sub   = {acc_r[65], acc_r} - {prod_r[65], prod_r};
  assign sq_t      = rnd30(sum_add);
  assign mag       = (sq_t > 67'sd4294967296) ? 33'h1_0000_0000 : sq_t[32:0];
  assign gain_w    = 34'sd3221225472 - $signed({1'b0, mag});

  always_comb begin
    issue = 1'b0;
    if (state_r == RUN) begin
      if (step_r <= S_PI_SR) begin
        issue = 1'b1;
      end else if (renorm_r && step_r <= S_PI_G && step_r != S_GAIN) begin
        issue = 1'b1;
      end
    end
  end

  always_comb begin
    op_x = '0;
    op_y = '0;
    unique case (step_r)
      S_A_PR: begin
        op_x = {{17{a_r[15]}}, a_r};
        op_y = {pr_r[31], pr_r};
      end
      S_B_PI: begin
        op_x = {{17{b_r[15]}}, b_r};
        op_y = {pi_r[31], pi_r};
      end
      S_A_PI: begin
        op_x = {{17{a_r[15]}}, a_r};
        op_y = {pi_r[31], pi_r};
      end
      S_B_PR: begin
        op_x = {{17{b_r[15]}}, b_r};
        op_y = {pr_r[31], pr_r};
      end
      S_PR_SR: begin
        op_x = {pr_r[31], pr_r};
        op_y = {{2{cfg.step_real[30]}}, cfg.step_real};
      end
      S_PI_SI: begin
        op_x = {pi_r[31], pi_r};
        op_y = {{2{cfg.step_imag[30]}}, cfg.step_imag};
      end
      S_PR_SI: begin
        op_x = {pr_r[31], pr_r};
        op_y = {{2{cfg.step_imag[30]}}, cfg.step_imag};
      end
      S_PI_SR: begin
        op_x = {pi_r[31], pi_r};
        op_y = {{2{cfg.step_real[30]}}, cfg.step_real};
      end
      S_PR_SQ: begin
        op_x = {pr_r[31], pr_r};
        op_y = {pr_r[31], pr_r};
      end
      S_PI_SQ: begin
        op_x = {pi_r[31], pi_r};
        op_y = {pi_r[31], pi_r};
      end
      S_PR_G: begin
        op_x = {pr_r[31], pr_r};
        op_y = g_r;
      end
      S_PI_G: begin
        op_x = {pi_r[31], pi_r};
        op_y = g_r;
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      prod_r <= mul;
    end
    tag_r <= step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      step_r      <= S_A_PR;
      pvalid_r    <= 1'b0;
      renorm_r    <= 1'b0;
      rcount_r    <= '0;
      pr_r        <= ONE_Q30;
      pi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pvalid_r <= issue;
      if (out_valid_r && out_ready && !(state_r == HOLD && keep_r)) begin
        out_valid_r <= 1'b0;
      end
      if (pvalid_r) begin
        unique case (tag_r) inside
          S_A_PR, S_A_PI, S_PR_SR, S_PR_SI, S_PR_SQ: acc_r <= prod_r;
          S_B_PI:  yr_r <= sat16(rnd30(sum_sub));
          S_B_PR:  yi_r <= sat16(rnd30(sum_add));
          S_PI_SI: pr_r <= sat32(rnd30(sum_sub));
          S_PI_SR: pi_r <= sat32(rnd30(sum_add));
          S_PI_SQ: g_r  <= gain_w[32:0];
          S_PR_G:  pr_r <= sat32(rnd31({prod_r[65], prod_r}));
          S_PI_G:  pi_r <= sat32(rnd31({prod_r[65], prod_r}));
          default: ;
        endcase
      end
      unique case (state_r)
        IDLE: begin
          if (q_valid) begin
            a_r    <= q_item.sample.in_real;
            b_r    <= q_item.sample.in_imag;
            keep_r <= q_item.keep;
            if (cfg.mix_enable) begin
              state_r <= RUN;
              step_r  <= S_A_PR;
              if (rcount_r == RW'(RENORM_PERIOD - 1)) begin
                renorm_r <= 1'b1;
                rcount_r <= '0;
              end else begin
                renorm_r <= 1'b0;
                rcount_r <= rcount_r + RW'(1);
              end
            end else begin
              yr_r    <= q_item.sample.in_real;
              yi_r    <= q_item.sample.in_imag;
              state_r <= HOLD;
            end
          end
        end
        RUN: begin
          step_r <= step_r + 4'd1;
          if (step_r == end_step) begin
            state_r <= HOLD;
          end
        end
        HOLD: begin
          if (!keep_r) begin
            state_r <= IDLE;
          end else if (!out_valid_r || out_ready) begin
            out_valid_r    <= 1'b1;
            out_r.out_real <= yr_r;
            out_r.out_imag <= yi_r;
            state_r        <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/complex_mixer_decimator.sv
// Top level of the complex mixer and decimator with its register file.
//
// Usage: samples enter on in_valid/in_ready/in_data, one complex Q1.15 item
// each. Kept results leave on out_valid/out_ready/out_data; dropped samples
// produce no item. Registers are written on cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high. Writes must be made
// only while the block is idle; the block itself does not enforce this.
// An accepted input passes through the queue and the back end to the output
// register; with mixing on, the back end first steps through the mixing and
// phasor-step products, and also the renormalization products on a sample
// that renormalizes the phasor. The back end takes one item at a time and
// forms every product on the single shared 33x33 multiplier.
// A two-entry queue lets the front end accept items while the back end works.
// Reset restores the register defaults, a unit phasor and cleared counters.
// When the receiver stalls, the result holds in the output register, the
// back end waits after its next result, and in_ready falls once the queue
// is full.
`default_nettype none

module complex_mixer_decimator #(
  parameter int RENORM_PERIOD = 512,
  parameter int MAX_DECIM     = 1024
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  cmxd_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output cmxd_pkg::out_item_t                 out_data,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [cmxd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [cmxd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cmxd_pkg::*;

  cfg_t    cfg_r;
  logic    q_push;
  q_item_t q_push_item;
  logic    q_full;
  logic    q_pop;
  logic    q_valid;
  q_item_t q_pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mix_enable   <= 1'b0;
      cfg_r.step_real    <= ONE_Q30[30:0];
      cfg_r.step_imag    <= '0;
      cfg_r.decim_factor <= 11'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIX_ENABLE:   cfg_r.mix_enable   <= cfg_data[0];
        CFG_STEP_REAL:    cfg_r.step_real    <= cfg_data[30:0];
        CFG_STEP_IMAG:    cfg_r.step_imag    <= cfg_data[30:0];
        CFG_DECIM_FACTOR: cfg_r.decim_factor <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  cmxd_front #(
    .MAX_DECIM(MAX_DECIM)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .decim_factor (cfg_r.decim_factor),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_push_item)
  );

  cmxd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_pop_item)
  );

  cmxd_back #(
    .RENORM_PERIOD(RENORM_PERIOD)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_pop_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> src/cmxd_checker.sv
// Port-level checks for the complex mixer and decimator, bound to the top level.
`default_nettype none

module cmxd_checker (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_ready,
  input wire                   out_valid,
  input wire                   out_ready,
  input cmxd_pkg::out_item_t   out_data,
  input wire                   cfg_ready
);
  import cmxd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result item changed or vanished while stalled.");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("Block not empty and ready after reset.");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("Configuration port refused a write.");

  a_no_early_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid ##1 !out_valid)
    else $error("Result item appeared too soon after reset.");

endmodule

bind complex_mixer_decimator cmxd_checker u_cmxd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
